/* rtl/lpe_pkg.sv */
package lpe_pkg;

  localparam int COORD_W    = 9;
  localparam int ADDR_W     = 18;
  localparam int SAMPLE_W   = 16;
  localparam int ERR_W      = 11;
  localparam int SLOT_COUNT = 7;
  localparam int MEAN_SLOTS = 6;
  localparam int SLOT_IDX_W = 3;
  // slots only ever rise from zero, so they hold non-negative values
  localparam int SLOT_W     = 15;
  localparam int SUM_W      = 18;
  localparam int WINDOW_W   = 15;
  localparam int MODE_W     = 2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // sum / 6 as (sum * ceil(2^21 / 6)) >> 21, exact for sums below 2^19
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP_SIX = RECIP_W'(((1 << RECIP_SHIFT) + 5) / 6);
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ABSOLUTE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WINDOW   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ABSOLUTE_CAP = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FLOOR_VALUE  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_WIDTH = 2'd3;

  localparam logic [MODE_W-1:0]          FILTER_MODE_RESET  = MODE_WINDOW;
  localparam logic signed [SAMPLE_W-1:0] ABSOLUTE_CAP_RESET = 16'sd5727;
  localparam logic signed [SAMPLE_W-1:0] FLOOR_VALUE_RESET  = 16'sd0;
  localparam logic [WINDOW_W-1:0]        WINDOW_WIDTH_RESET = 15'd1536;

  localparam logic signed [SAMPLE_W-1:0] MIN_INIT = 16'sd32767;

  typedef struct packed {
    logic                       operation;
    logic [COORD_W-1:0]         x_start;
    logic [COORD_W-1:0]         y_start;
    logic [COORD_W-1:0]         x_end;
    logic [COORD_W-1:0]         y_end;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       sample_missing;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]          fetch_address;
    logic                       line_done;
    logic signed [SAMPLE_W-1:0] profile_mean;
    logic signed [SAMPLE_W-1:0] profile_min;
    logic                       sequence_error;
  } out_t;

endpackage

/* rtl/line_profile_extremes.sv */
// line walker with min and capped-max statistics
// a result passes the stage-one registers, then the output register
// throughput: one request per cycle unless out_ready stalls; the walk step, slot compare and
//   running slot sum settle in stage one, divide by six (reciprocal multiply) in stage two
// reset: synchronous; all but stage data registers reset; no line active, both stages empty
module line_profile_extremes #(
  parameter int IMAGE_WIDTH = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lpe_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lpe_pkg::out_t                     out_data,
  input  logic                              cfg_write,
  input  logic [lpe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lpe_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lpe_pkg::*;

  // configuration
  logic [MODE_W-1:0]          filter_mode;
  logic signed [SAMPLE_W-1:0] absolute_cap;
  logic signed [SAMPLE_W-1:0] floor_value;
  logic [WINDOW_W-1:0]        window_width;

  // walk state
  logic [COORD_W-1:0]      cur_row, cur_col, end_row, end_col;
  logic [COORD_W-1:0]      delta_row, delta_col;
  logic                    row_step_down, col_step_down;
  logic signed [ERR_W-1:0] step_error;
  logic                    line_active;

  // statistics
  logic [SLOT_W-1:0]          max_slots [SLOT_COUNT];
  logic [SLOT_IDX_W-1:0]      slot_index;
  logic [SUM_W-1:0]           slot_sum;
  logic signed [SAMPLE_W-1:0] running_min;

  // next values
  logic [COORD_W-1:0]         cur_row_next, cur_col_next;
  logic signed [ERR_W-1:0]    step_error_next;
  logic                       line_active_next;
  logic [SLOT_IDX_W-1:0]      slot_index_next;
  logic [SUM_W-1:0]           slot_sum_next;
  logic signed [SAMPLE_W-1:0] running_min_next;

  // first stage
  logic                       s1_valid;
  logic [ADDR_W-1:0]          s1_addr;
  logic                       s1_done;
  logic [SUM_W-1:0]           s1_sum;
  logic signed [SAMPLE_W-1:0] s1_min;
  logic                       s1_err;
  logic [ADDR_W-1:0]          s1_addr_next;
  logic                       s1_done_next;
  logic                       s1_err_next;

  logic s1_advance, accept;

  // combinational helpers
  logic signed [SAMPLE_W-1:0] s;
  logic [SLOT_W-1:0]          slot_old;
  logic                       cap_ok, slot_take, at_end;
  logic signed [SAMPLE_W+1:0] rel_sample;
  logic [COORD_W-1:0]         r0, c0, r1, c1, dr_start, dc_start;
  logic signed [ERR_W-1:0]    dr_ext, dc_ext;
  logic [COORD_W-1:0]         addr_row, addr_col;
  logic [ADDR_W:0]            addr_full;
  logic [PROD_W-1:0]          mean_prod;

  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;
  assign accept     = in_valid && in_ready;

  assign s        = in_data.sample_value;
  assign slot_old = max_slots[slot_index];
  assign at_end   = (cur_row == end_row) && (cur_col == end_col);
  assign dr_ext   = $signed({2'b00, delta_row});
  assign dc_ext   = $signed({2'b00, delta_col});

  assign r0 = in_data.x_start;
  assign c0 = in_data.y_start;
  assign r1 = in_data.x_end;
  assign c1 = in_data.y_end;
  assign dr_start = (r0 < r1) ? r1 - r0 : r0 - r1;
  assign dc_start = (c0 < c1) ? c1 - c0 : c0 - c1;

  assign rel_sample = (SAMPLE_W+2)'(s) - (SAMPLE_W+2)'(floor_value);

  always_comb begin
    unique case (filter_mode)
      MODE_ABSOLUTE: cap_ok = s < absolute_cap;
      MODE_WINDOW:   cap_ok = rel_sample < $signed({3'b000, window_width});
      default:       cap_ok = 1'b1;
    endcase
  end

  assign slot_take = !in_data.sample_missing && (s > $signed({1'b0, slot_old})) && cap_ok;

  always_comb begin
    cur_row_next     = cur_row;
    cur_col_next     = cur_col;
    step_error_next  = step_error;
    line_active_next = line_active;
    slot_index_next  = slot_index;
    slot_sum_next    = slot_sum;
    running_min_next = running_min;
    s1_done_next     = 1'b0;
    s1_err_next      = 1'b0;
    addr_row         = cur_row;
    addr_col         = cur_col;
    s1_addr_next     = '0;
    if (in_data.operation == OP_START) begin
      cur_row_next     = r0;
      cur_col_next     = c0;
      step_error_next  = (dr_start > dc_start) ? $signed(ERR_W'(dr_start >> 1))
                                               : -$signed(ERR_W'(dc_start >> 1));
      line_active_next = 1'b1;
      slot_index_next  = '0;
      slot_sum_next    = '0;
      running_min_next = MIN_INIT;
      addr_row         = r0;
      addr_col         = c0;
    end else if (!line_active) begin
      s1_err_next = 1'b1;
    end else begin
      if (slot_take) begin
        slot_index_next = (slot_index == SLOT_IDX_W'(SLOT_COUNT - 1)) ? '0 : slot_index + 1'b1;
        if (slot_index < SLOT_IDX_W'(MEAN_SLOTS))
          slot_sum_next = slot_sum + SUM_W'(s[SLOT_W-1:0]) - SUM_W'(slot_old);
      end
      if (!in_data.sample_missing && (s < running_min))
        running_min_next = s;
      if (at_end) begin
        s1_done_next     = 1'b1;
        line_active_next = 1'b0;
      end else begin
        if (step_error > -dr_ext) begin
          step_error_next = step_error_next - dc_ext;
          cur_row_next    = row_step_down ? cur_row - 1'b1 : cur_row + 1'b1;
        end
        if (step_error < dc_ext) begin
          step_error_next = step_error_next + dr_ext;
          cur_col_next    = col_step_down ? cur_col - 1'b1 : cur_col + 1'b1;
        end
        addr_row = cur_row_next;
        addr_col = cur_col_next;
      end
    end
    addr_full = (ADDR_W+1)'(addr_row) * (ADDR_W+1)'(IMAGE_WIDTH) + (ADDR_W+1)'(addr_col);
    if (!s1_err_next && !s1_done_next)
      s1_addr_next = addr_full[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= FILTER_MODE_RESET;
      absolute_cap <= ABSOLUTE_CAP_RESET;
      floor_value  <= FLOOR_VALUE_RESET;
      window_width <= WINDOW_WIDTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FILTER_MODE:  filter_mode  <= cfg_data[MODE_W-1:0];
        REG_ABSOLUTE_CAP: absolute_cap <= $signed(cfg_data);
        REG_FLOOR_VALUE:  floor_value  <= $signed(cfg_data);
        REG_WINDOW_WIDTH: window_width <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row       <= '0;
      cur_col       <= '0;
      end_row       <= '0;
      end_col       <= '0;
      delta_row     <= '0;
      delta_col     <= '0;
      row_step_down <= 1'b0;
      col_step_down <= 1'b0;
      step_error    <= '0;
      line_active   <= 1'b0;
      slot_index    <= '0;
      slot_sum      <= '0;
      running_min   <= MIN_INIT;
      for (int k = 0; k < SLOT_COUNT; k++) max_slots[k] <= '0;
    end else if (accept) begin
      cur_row     <= cur_row_next;
      cur_col     <= cur_col_next;
      step_error  <= step_error_next;
      line_active <= line_active_next;
      slot_index  <= slot_index_next;
      slot_sum    <= slot_sum_next;
      running_min <= running_min_next;
      if (in_data.operation == OP_START) begin
        end_row       <= r1;
        end_col       <= c1;
        delta_row     <= dr_start;
        delta_col     <= dc_start;
        row_step_down <= !(r0 < r1);
        col_step_down <= !(c0 < c1);
        for (int k = 0; k < SLOT_COUNT; k++) max_slots[k] <= '0;
      end else if (line_active && slot_take) begin
        max_slots[slot_index] <= s[SLOT_W-1:0];
      end
    end
  end

  // stage one: walk result plus slot sum for the mean
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (accept) begin
      s1_addr <= s1_addr_next;
      s1_done <= s1_done_next;
      s1_sum  <= s1_done_next ? slot_sum_next : '0;
      s1_min  <= running_min_next;
      s1_err  <= s1_err_next;
    end
  end

  assign mean_prod = PROD_W'(s1_sum) * PROD_W'(RECIP_SIX);

  // stage two: divide by six, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
    if (s1_advance && s1_valid) begin
      out_data.fetch_address  <= s1_addr;
      out_data.line_done      <= s1_done;
      out_data.profile_mean   <= $signed(mean_prod[RECIP_SHIFT +: SAMPLE_W]);
      out_data.profile_min    <= s1_min;
      out_data.sequence_error <= s1_err;
    end
  end

endmodule
